// ===== sv/lid_pkg.sv =====
// shared types and constants for the line intersection dedup block
// no dependencies
package lid_pkg;

	localparam int MAX_POINTS = 512;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int CRD_W      = 13;
	localparam int PT_W       = 20;
	localparam int NUM_W      = 45;
	localparam int DEN_W      = 29;
	localparam int NMAG_W     = 44;
	localparam int DMAG_W     = 28;
	localparam int DCNT_W     = $clog2(NMAG_W + 1);
	localparam int OFS_W      = 12;
	localparam int THR_W      = 32;
	localparam logic signed [PT_W-1:0] PAR_POINT = -PT_W'(16);
	localparam logic signed [PT_W-1:0] SAT_HI    = PT_W'(524287);
	localparam logic signed [PT_W-1:0] SAT_LO    = -PT_W'(524288);
	localparam logic [OFS_W-1:0] OFS_RESET = OFS_W'(10);

	typedef struct packed {
		logic signed [PT_W-1:0] x;
		logic signed [PT_W-1:0] y;
	} point_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

// ===== sv/lid_cell.sv =====
// one stage of the point ring: holds a stored point, loads a new one or shifts from its neighbor
// depends on lid_pkg
module lid_cell (
	input  logic              clk,
	input  lid_pkg::cell_ctl_t ctl,
	input  lid_pkg::point_t   nb,
	input  lid_pkg::point_t   din,
	output lid_pkg::point_t   q
);
	import lid_pkg::*;

	point_t pt_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pt_q <= din;
		end else if (ctl.shift) begin
			pt_q <= nb;
		end
	end

	assign q = pt_q;

endmodule

// ===== sv/lid_div.sv =====
// bit-serial signed divider with truncation toward zero and 20 bit saturation
// depends on lid_pkg
module lid_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [lid_pkg::NUM_W-1:0]  num,
	input  logic signed [lid_pkg::DEN_W-1:0]  den,
	output logic                              done,
	output logic signed [lid_pkg::PT_W-1:0]   quo
);
	import lid_pkg::*;

	logic [NMAG_W-1:0] nmag_q;
	logic [NMAG_W-1:0] qmag_q;
	logic [DMAG_W-1:0] dmag_q;
	logic [DMAG_W-1:0] rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              neg_q;
	logic              run_q;
	logic              done_q;
	logic [DMAG_W:0]   trial;
	logic              ge;
	logic [NUM_W-1:0]  nabs;
	logic [DEN_W-1:0]  dabs;

	assign nabs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign dabs  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
	assign trial = {rem_q, nmag_q[NMAG_W-1]};
	assign ge    = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DCNT_W'(NMAG_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= num[NUM_W-1] ^ den[DEN_W-1];
			nmag_q <= nabs[NMAG_W-1:0];
			dmag_q <= dabs[DMAG_W-1:0];
			rem_q  <= '0;
			qmag_q <= '0;
		end else if (run_q) begin
			rem_q  <= ge ? DMAG_W'(trial - {1'b0, dmag_q}) : DMAG_W'(trial);
			qmag_q <= {qmag_q[NMAG_W-2:0], ge};
			nmag_q <= {nmag_q[NMAG_W-2:0], 1'b0};
		end
	end

	always_comb begin
		if (neg_q) begin
			if (qmag_q > NMAG_W'(524288)) begin
				quo = SAT_LO;
			end else begin
				quo = -$signed(qmag_q[PT_W-1:0]);
			end
		end else begin
			if (qmag_q > NMAG_W'(524287)) begin
				quo = SAT_HI;
			end else begin
				quo = $signed(qmag_q[PT_W-1:0]);
			end
		end
	end

	assign done = done_q;

endmodule

// ===== sv/line_intersection_dedup_top.sv =====
// top level: line pair intersection, ring of stored points for duplicate search
// depends on lid_pkg, lid_div, lid_cell
//
// One item is taken at a time. A clear item goes from acceptance straight to the
// output state. A line pair passes the accepting state, the multiply stages
// ST_M1 to ST_M4, a divider start state, the bit-serial dividers (skipped
// for parallel lines) and one full turn of the point ring, during
// which each stored point passes the single distance compare unit, then the
// compare pipeline, decision and output; the output state waits while the output is
// stalled. The ring turns fully for every line pair, so the time does not depend
// on the fill level.
// max_offset is written and read back at any address (paddr is not decoded), in bits 11:0.
module line_intersection_dedup_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [1:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic signed [12:0]              a_start_x,
	input  logic signed [12:0]              a_start_y,
	input  logic signed [12:0]              a_end_x,
	input  logic signed [12:0]              a_end_y,
	input  logic signed [12:0]              b_start_x,
	input  logic signed [12:0]              b_start_y,
	input  logic signed [12:0]              b_end_x,
	input  logic signed [12:0]              b_end_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [19:0]              point_x,
	output logic signed [19:0]              point_y,
	output logic                            lines_parallel,
	output logic                            was_added,
	output logic                            store_full_drop,
	output logic [9:0]                      point_count
);
	import lid_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_DIVS, ST_DIVW,
		ST_SCAN, ST_DRAIN, ST_DECIDE, ST_DONE
	} state_t;

	state_t state_q;

	logic [OFS_W-1:0] max_offset_q;
	logic [THR_W-1:0] thr_q;

	logic signed [CRD_W-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
	logic signed [CRD_W:0]   dx12_q, dy12_q, dx34_q, dy34_q;
	logic signed [25:0]      p1_q, p2_q, p3_q, p4_q;
	logic signed [26:0]      ca_q, cb_q;
	logic signed [DEN_W-1:0] m1_q, m2_q, d_q;
	logic signed [40:0]      t1_q, t2_q, t3_q, t4_q;
	logic signed [NUM_W-1:0] nx_q, ny_q;

	logic                    div_start;
	logic                    div_done_x, div_done_y;
	logic signed [PT_W-1:0]  qx, qy;

	point_t                  cand_q;
	point_t                  ring [MAX_POINTS];
	logic [MAX_POINTS-1:0]   load_vec;
	logic                    ring_shift;

	logic [IDX_W:0]          scan_q;
	logic                    drain_q;
	logic [CNT_W-1:0]        count_q;
	logic                    dup_q;
	logic signed [PT_W:0]    dx_s1, dy_s1;
	logic                    v_s1;
	logic [2*PT_W+1:0]       sx_s2, sy_s2;
	logic                    v_s2;
	logic                    do_add;

	point_t                  res_pt_q;
	logic                    res_par_q, res_add_q, res_drop_q;
	logic [CNT_W-1:0]        res_cnt_q;

	logic                    out_valid_q;
	point_t                  out_pt_q;
	logic                    out_par_q, out_add_q, out_drop_q;
	logic [9:0]              out_cnt_q;

	// config port
	assign pready = 1'b1;
	assign prdata = 32'(max_offset_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_offset_q <= OFS_RESET;
		end else if (psel && penable && pwrite) begin
			max_offset_q <= pwdata[OFS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		thr_q <= THR_W'(24'(max_offset_q) * 24'(max_offset_q)) << 8;
	end

	// intersection arithmetic
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			x1_q <= a_start_x; y1_q <= a_start_y;
			x2_q <= a_end_x;   y2_q <= a_end_y;
			x3_q <= b_start_x; y3_q <= b_start_y;
			x4_q <= b_end_x;   y4_q <= b_end_y;
		end
		dx12_q <= 14'(x1_q) - 14'(x2_q);
		dy12_q <= 14'(y1_q) - 14'(y2_q);
		dx34_q <= 14'(x3_q) - 14'(x4_q);
		dy34_q <= 14'(y3_q) - 14'(y4_q);
		p1_q   <= 26'(x1_q) * 26'(y2_q);
		p2_q   <= 26'(y1_q) * 26'(x2_q);
		p3_q   <= 26'(x3_q) * 26'(y4_q);
		p4_q   <= 26'(y3_q) * 26'(x4_q);
		ca_q   <= 27'(p1_q) - 27'(p2_q);
		cb_q   <= 27'(p3_q) - 27'(p4_q);
		m1_q   <= DEN_W'(dx12_q) * DEN_W'(dy34_q);
		m2_q   <= DEN_W'(dy12_q) * DEN_W'(dx34_q);
		d_q    <= m1_q - m2_q;
		t1_q   <= 41'(ca_q) * 41'(dx34_q);
		t2_q   <= 41'(dx12_q) * 41'(cb_q);
		t3_q   <= 41'(ca_q) * 41'(dy34_q);
		t4_q   <= 41'(dy12_q) * 41'(cb_q);
		nx_q   <= (NUM_W'(t1_q) - NUM_W'(t2_q)) <<< 4;
		ny_q   <= (NUM_W'(t3_q) - NUM_W'(t4_q)) <<< 4;
	end

	assign div_start = (state_q == ST_DIVS) && (d_q != '0);

	lid_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (nx_q),
		.den    (d_q),
		.done   (div_done_x),
		.quo    (qx)
	);

	lid_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ny_q),
		.den    (d_q),
		.done   (div_done_y),
		.quo    (qy)
	);

	// point ring
	assign ring_shift = (state_q == ST_SCAN);
	assign do_add     = !dup_q && (count_q < CNT_W'(MAX_POINTS));

	always_comb begin
		load_vec = '0;
		if (state_q == ST_DECIDE && do_add) begin
			load_vec[count_q[IDX_W-1:0]] = 1'b1;
		end
	end

	for (genvar j = 0; j < MAX_POINTS; j++) begin : g_ring
		cell_ctl_t ctl;
		assign ctl.shift = ring_shift;
		assign ctl.load  = load_vec[j];
		lid_cell u_cell (
			.clk (clk),
			.ctl (ctl),
			.nb  (ring[(j + 1) % MAX_POINTS]),
			.din (cand_q),
			.q   (ring[j])
		);
	end

	// distance compare pipeline at the ring head
	always_ff @(posedge clk) begin
		dx_s1 <= (PT_W+1)'(ring[0].x) - (PT_W+1)'(cand_q.x);
		dy_s1 <= (PT_W+1)'(ring[0].y) - (PT_W+1)'(cand_q.y);
		sx_s2 <= (2*PT_W+2)'((2*PT_W+2)'(dx_s1) * (2*PT_W+2)'(dx_s1));
		sy_s2 <= (2*PT_W+2)'((2*PT_W+2)'(dy_s1) * (2*PT_W+2)'(dy_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN) && (CNT_W'(scan_q) < count_q);
			v_s2 <= v_s1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			drain_q     <= 1'b0;
			dup_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DIVS) begin
				dup_q <= 1'b0;
			end else if (v_s2 && ((sx_s2 + sy_s2) < (2*PT_W+2)'(thr_q))) begin
				dup_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (opcode) begin
							count_q    <= '0;
							res_pt_q   <= '0;
							res_par_q  <= 1'b0;
							res_add_q  <= 1'b0;
							res_drop_q <= 1'b0;
							res_cnt_q  <= '0;
							state_q    <= ST_DONE;
						end else begin
							state_q <= ST_M1;
						end
					end
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_DIVS;
				ST_DIVS: begin
					scan_q <= '0;
					if (d_q == '0) begin
						cand_q.x  <= PAR_POINT;
						cand_q.y  <= PAR_POINT;
						res_par_q <= 1'b1;
						state_q   <= ST_SCAN;
					end else begin
						res_par_q <= 1'b0;
						state_q   <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_done_x && div_done_y) begin
						cand_q.x <= qx;
						cand_q.y <= qy;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == (IDX_W+1)'(MAX_POINTS - 1)) begin
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					res_pt_q   <= cand_q;
					res_add_q  <= do_add;
					res_drop_q <= !dup_q && !do_add;
					res_cnt_q  <= do_add ? count_q + 1'b1 : count_q;
					if (do_add) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_pt_q    <= res_pt_q;
						out_par_q   <= res_par_q;
						out_add_q   <= res_add_q;
						out_drop_q  <= res_drop_q;
						out_cnt_q   <= 10'(res_cnt_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall        = (state_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign point_x         = out_pt_q.x;
	assign point_y         = out_pt_q.y;
	assign lines_parallel  = out_par_q;
	assign was_added       = out_add_q;
	assign store_full_drop = out_drop_q;
	assign point_count     = out_cnt_q;

endmodule

// ===== tb/tb_line_intersection_dedup_top.sv =====
// testbench for line_intersection_dedup_top: directed table, then random phases
// checks every result against a fixed table value or an in-bench predictor of intersection and dedup
// depends on lid_pkg and the top level
`timescale 1ns / 1ps

module tb_line_intersection_dedup_top;
	import lid_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 600;

	typedef struct {
		logic                  op;
		logic signed [12:0]    c [8];
	} line_item_t;

	typedef struct packed {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic               par;
		logic               added;
		logic               drop;
		logic [9:0]         cnt;
	} point_result_t;

	typedef struct {
		line_item_t    it;
		bit            known;
		point_result_t r;
	} table_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [1:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic opcode = 0;
	logic signed [12:0] a_start_x = 0, a_start_y = 0, a_end_x = 0, a_end_y = 0;
	logic signed [12:0] b_start_x = 0, b_start_y = 0, b_end_x = 0, b_end_y = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [19:0] point_x, point_y;
	logic lines_parallel, was_added, store_full_drop;
	logic [9:0] point_count;

	line_intersection_dedup_top DUT (.*);

	point_t        store_pts [MAX_POINTS];
	int            store_cnt;
	logic [11:0]   dup_ofs;
	point_result_t expected_q [$];
	table_row_t    dir_rows [$];
	point_t        recent_pts [$];
	int            errors = 0;
	int            send_pct = 0;
	int            stall_pct = 0;
	int            idle_cnt = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt == WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		point_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result x=%0d y=%0d", $time, point_x, point_y);
			end else begin
				e = expected_q.pop_front();
				if (e.x !== point_x || e.y !== point_y || e.par !== lines_parallel ||
				    e.added !== was_added || e.drop !== store_full_drop ||
				    e.cnt !== point_count) begin
					errors++;
					$display("%0t mismatch exp x=%0d y=%0d par=%0b add=%0b drop=%0b cnt=%0d",
						$time, e.x, e.y, e.par, e.added, e.drop, e.cnt);
					$display("%0t          act x=%0d y=%0d par=%0b add=%0b drop=%0b cnt=%0d",
						$time, point_x, point_y, lines_parallel, was_added,
						store_full_drop, point_count);
				end
			end
		end
	end

	function automatic longint sat_pt(longint q);
		if (q > 524287) return 524287;
		if (q < -524288) return -524288;
		return q;
	endfunction

	function automatic point_result_t predict_point(line_item_t it);
		point_result_t r;
		longint x1, y1, x2, y2, x3, y3, x4, y4, d, ca, cb, px, py, thr, dx, dy;
		bit dup;
		r = '0;
		if (it.op) begin
			store_cnt = 0;
			return r;
		end
		x1 = it.c[0]; y1 = it.c[1]; x2 = it.c[2]; y2 = it.c[3];
		x3 = it.c[4]; y3 = it.c[5]; x4 = it.c[6]; y4 = it.c[7];
		d = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
		if (d == 0) begin
			r.par = 1;
			px = -16;
			py = -16;
		end else begin
			ca = x1 * y2 - y1 * x2;
			cb = x3 * y4 - y3 * x4;
			px = sat_pt(((ca * (x3 - x4) - (x1 - x2) * cb) * 16) / d);
			py = sat_pt(((ca * (y3 - y4) - (y1 - y2) * cb) * 16) / d);
		end
		thr = (longint'(dup_ofs) * 16) * (longint'(dup_ofs) * 16);
		dup = 0;
		for (int i = 0; i < store_cnt; i++) begin
			dx = longint'(store_pts[i].x) - px;
			dy = longint'(store_pts[i].y) - py;
			if (dx * dx + dy * dy < thr) dup = 1;
		end
		r.x = px[19:0];
		r.y = py[19:0];
		if (!dup) begin
			if (store_cnt < MAX_POINTS) begin
				store_pts[store_cnt].x = px[19:0];
				store_pts[store_cnt].y = py[19:0];
				store_cnt++;
				r.added = 1;
			end else begin
				r.drop = 1;
			end
		end
		r.cnt = 10'(store_cnt);
		return r;
	endfunction

	function automatic line_item_t make_item(logic op, int v0, int v1, int v2, int v3,
		int v4, int v5, int v6, int v7);
		line_item_t it;
		it.op = op;
		it.c[0] = 13'(v0); it.c[1] = 13'(v1); it.c[2] = 13'(v2); it.c[3] = 13'(v3);
		it.c[4] = 13'(v4); it.c[5] = 13'(v5); it.c[6] = 13'(v6); it.c[7] = 13'(v7);
		return it;
	endfunction

	task automatic add_row(line_item_t it, bit known, point_result_t r);
		table_row_t row;
		row.it = it;
		row.known = known;
		row.r = r;
		dir_rows = {dir_rows, row};
	endtask

	function automatic int rnd_s(int lim);
		return int'($urandom_range(2 * lim)) - lim;
	endfunction

	function automatic line_item_t random_item(int clear_pct);
		line_item_t it;
		int k, px, py, u1, v1, u2, v2;
		point_t p;
		k = $urandom_range(99);
		for (int i = 0; i < 8; i++) it.c[i] = 13'($urandom_range(8191));
		it.op = (k < clear_pct);
		if (it.op) return it;
		k = $urandom_range(99);
		if (k < 12) begin
			// parallel pair, b is a shifted copy of a
			u1 = rnd_s(60); v1 = rnd_s(60);
			px = rnd_s(4000); py = rnd_s(4000);
			it = make_item(0, px, py, px + u1, py + v1, rnd_s(4000), rnd_s(4000), 0, 0);
			it.c[6] = it.c[4] + 13'(u1);
			it.c[7] = it.c[5] + 13'(v1);
			if (it.c[4] > 4000 || it.c[4] < -4000 || it.c[5] > 4000 || it.c[5] < -4000) begin
				it.c[4] = 13'(rnd_s(3000));
				it.c[5] = 13'(rnd_s(3000));
				it.c[6] = it.c[4] + 13'(u1);
				it.c[7] = it.c[5] + 13'(v1);
			end
		end else if (k < 60) begin
			// lines crossing at a chosen pixel, often near an earlier one
			if (recent_pts.size() > 0 && $urandom_range(1)) begin
				p = recent_pts[$urandom_range(recent_pts.size() - 1)];
				px = int'(p.x) + rnd_s(20);
				py = int'(p.y) + rnd_s(20);
			end else begin
				px = rnd_s(2000);
				py = rnd_s(2000);
				p.x = 20'(px); p.y = 20'(py);
				recent_pts = {recent_pts, p};
				if (recent_pts.size() > 16) void'(recent_pts.pop_front());
			end
			u1 = rnd_s(50); v1 = rnd_s(50); u2 = rnd_s(50); v2 = rnd_s(50);
			it = make_item(0, px + u1, py + v1, px, py, px, py, px + u2, py + v2);
			if ($urandom_range(1)) it = make_item(0, px, py, px + u1, py + v1,
				px - u2, py - v2, px + u2, py + v2);
		end
		return it;
	endfunction

	task automatic send_item(line_item_t it);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid  <= 1;
		opcode    <= it.op;
		a_start_x <= it.c[0]; a_start_y <= it.c[1];
		a_end_x   <= it.c[2]; a_end_y   <= it.c[3];
		b_start_x <= it.c[4]; b_start_y <= it.c[5];
		b_end_x   <= it.c[6]; b_end_y   <= it.c[7];
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_offset(logic [11:0] val);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= 0;
		pwdata  <= {20'($urandom), val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
		dup_ofs = val;
	endtask

	task automatic run_phase(logic [11:0] ofs, int sp, int stp, int n, int clear_pct);
		line_item_t it;
		wait_drained();
		write_offset(ofs);
		send_pct = sp;
		stall_pct = stp;
		for (int i = 0; i < n; i++) begin
			it = random_item(clear_pct);
			send_item(it);
			expected_q = {expected_q, predict_point(it)};
		end
	endtask

	initial begin
		point_result_t z, pr;
		point_result_t got;
		z = '0;
		pr = '0;
		pr.x = -20'sd16; pr.y = -20'sd16; pr.par = 1; pr.added = 1; pr.cnt = 1;
		store_cnt = 0;
		dup_ofs = OFS_RESET;

		add_row(make_item(1, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
		add_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, pr);
		pr.added = 0;
		add_row(make_item(0, 5, 5, 5, 5, 9, 9, 9, 9), 1, pr);
		add_row(make_item(0, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095), 1, pr);
		add_row(make_item(0, -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096), 1, pr);
		add_row(make_item(0, -4096, -4096, 4095, 4095, -4096, 4095, 4095, -4096), 0, z);
		add_row(make_item(0, 0, 0, 4095, 1, 0, 1, 4094, 2), 0, z);
		add_row(make_item(0, 0, 0, -4096, 1, 0, 1, -4095, 2), 0, z);
		add_row(make_item(0, 0, 0, 1, 4095, 1, 0, 2, 4094), 0, z);
		add_row(make_item(0, 0, 0, 1, -4096, 1, 0, 2, -4095), 0, z);
		add_row(make_item(0, 100, 200, 110, 200, 100, 200, 100, 210), 0, z);
		add_row(make_item(0, 100, 200, 90, 200, 100, 200, 100, 190), 0, z);
		add_row(make_item(0, 105, 200, 115, 200, 105, 200, 105, 210), 0, z);
		add_row(make_item(0, -3000, 1500, -2990, 1503, -3000, 1500, -3007, 1510), 0, z);
		add_row(make_item(0, 4095, -4096, -4096, 4095, -4096, -4096, 4095, 4094), 0, z);
		add_row(make_item(1, 4095, -4096, 4095, -4096, 4095, -4096, 4095, -4096), 1, z);
		add_row(make_item(1, -1, -1, -1, -1, -1, -1, -1, -1), 1, z);
		pr.added = 1;
		add_row(make_item(0, 1, 2, 3, 6, -7, 11, -5, 15), 1, pr);

		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].it);
			got = predict_point(dir_rows[i].it);
			expected_q = {expected_q, (dir_rows[i].known ? dir_rows[i].r : got)};
		end

		// zero offset fills the store and then drops
		run_phase(12'd0, 0, 0, 540, 0);
		run_phase(12'd4095, 76, 0, 140, 5);
		run_phase(12'd10, 0, 76, 140, 5);
		run_phase(12'($urandom_range(1, 40)), 9, 9, 140, 4);
		run_phase(12'($urandom_range(4095)), 0, 0, 150, 6);

		wait_drained();
		stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
